@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/stt_pkg.sv @@
`default_nettype none

package stt_pkg;

	localparam int SESSION_SLOTS_DEF = 32;
	localparam int SLOT_IDX_W = 5;

	// header type bytes
	localparam logic [7:0] TYPE_HANDSHAKE = 8'h01;
	localparam logic [7:0] TYPE_HS_ACK = 8'h02;
	localparam logic [7:0] TYPE_DATA = 8'h03;
	localparam logic [7:0] TYPE_ACK = 8'h04;
	localparam logic [7:0] TYPE_CLOSE = 8'h05;

	// result status codes
	localparam logic [3:0] ST_NEW = 4'd0;
	localparam logic [3:0] ST_HS_REPEAT = 4'd1;
	localparam logic [3:0] ST_FULL = 4'd2;
	localparam logic [3:0] ST_IN_ORDER = 4'd3;
	localparam logic [3:0] ST_AHEAD = 4'd4;
	localparam logic [3:0] ST_DUP = 4'd5;
	localparam logic [3:0] ST_DATA_UNKNOWN = 4'd6;
	localparam logic [3:0] ST_ACK_SEEN = 4'd7;
	localparam logic [3:0] ST_ACK_UNKNOWN = 4'd8;
	localparam logic [3:0] ST_CLOSED = 4'd9;
	localparam logic [3:0] ST_CLOSE_UNKNOWN = 4'd10;
	localparam logic [3:0] ST_BAD_TYPE = 4'd11;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture header, restart scan
		logic scan;    // read the slot at the scan counter
		logic commit;  // apply table update, load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/stt_ctrl.sv @@
`default_nettype none

module stt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  stt_pkg::stat_t stat,
	output stt_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			// last read is compared here
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/stt_datapath.sv @@
`default_nettype none

module stt_datapath #(
	parameter int SLOTS = stt_pkg::SESSION_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  stt_pkg::cmd_t  cmd,
	output stt_pkg::stat_t stat,
	input  logic [7:0]     packet_type,
	input  logic [63:0]    conn_id,
	input  logic [31:0]    seq_number,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [3:0]     status,
	output logic           send_reply,
	output logic [7:0]     reply_type,
	output logic [31:0]    reply_seq,
	output logic           slot_found,
	output logic [4:0]     slot_index
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SlotW = stt_pkg::SLOT_IDX_W;

	// captured header
	logic [7:0]  type_q;
	logic [63:0] id_q;
	logic [31:0] seq_q;

	// scan
	logic [IDX_W-1:0] cnt_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [63:0]      id_rd_s1;
	logic [31:0]      exp_rd_s1;

	logic             match_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [31:0]      exp_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	logic [SLOTS-1:0] active_q;
	logic [63:0]      id_mem [SLOTS];
	logic [31:0]      exp_mem [SLOTS];

	// result and update decode
	logic [3:0]       r_status;
	logic             r_reply;
	logic [7:0]       r_rtype;
	logic [31:0]      r_rseq;
	logic             r_found;
	logic [IDX_W-1:0] r_idx;
	logic             set_act;
	logic             clr_act;
	logic             wr_id;
	logic             wr_exp;
	logic [31:0]      wr_exp_val;
	logic [IDX_W-1:0] wr_idx;

	logic out_valid_q;

	assign stat.scan_last = (cnt_q == IDX_W'(SLOTS - 1));
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= packet_type;
			id_q <= conn_id;
			seq_q <= seq_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			match_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
			if (cmd.load) begin
				cnt_q <= '0;
				match_q <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (cmd.scan && !stat.scan_last) begin
					cnt_q <= cnt_q + 1'b1;
				end
				// keep only the lowest hit of each kind
				if (rd_vld_s1 && !match_q && active_q[idx_s1] && id_rd_s1 == id_q) begin
					match_q <= 1'b1;
				end
				if (rd_vld_s1 && !free_q && !active_q[idx_s1]) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (rd_vld_s1 && !match_q && active_q[idx_s1] && id_rd_s1 == id_q) begin
			match_idx_q <= idx_s1;
			exp_q <= exp_rd_s1;
		end
		if (rd_vld_s1 && !free_q && !active_q[idx_s1]) begin
			free_idx_q <= idx_s1;
		end
	end

	// slot memories
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_id) begin
			id_mem[wr_idx] <= id_q;
		end
		if (cmd.scan) begin
			id_rd_s1 <= id_mem[cnt_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && wr_exp) begin
			exp_mem[wr_idx] <= wr_exp_val;
		end
		if (cmd.scan) begin
			exp_rd_s1 <= exp_mem[cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cmd.commit) begin
			if (set_act) begin
				active_q[wr_idx] <= 1'b1;
			end else if (clr_act) begin
				active_q[wr_idx] <= 1'b0;
			end
		end
	end

	always_comb begin
		r_status = stt_pkg::ST_BAD_TYPE;
		r_reply = 1'b0;
		r_rtype = '0;
		r_rseq = '0;
		r_found = 1'b0;
		r_idx = match_idx_q;
		set_act = 1'b0;
		clr_act = 1'b0;
		wr_id = 1'b0;
		wr_exp = 1'b0;
		wr_exp_val = 32'd1;
		wr_idx = match_idx_q;
		case (type_q)
			stt_pkg::TYPE_HANDSHAKE: begin
				if (match_q) begin
					r_status = stt_pkg::ST_HS_REPEAT;
					r_reply = 1'b1;
					r_rtype = stt_pkg::TYPE_HS_ACK;
					r_found = 1'b1;
				end else if (free_q) begin
					r_status = stt_pkg::ST_NEW;
					r_reply = 1'b1;
					r_rtype = stt_pkg::TYPE_HS_ACK;
					r_found = 1'b1;
					r_idx = free_idx_q;
					set_act = 1'b1;
					wr_id = 1'b1;
					wr_exp = 1'b1;
					wr_idx = free_idx_q;
				end else begin
					r_status = stt_pkg::ST_FULL;
				end
			end
			stt_pkg::TYPE_DATA: begin
				if (match_q) begin
					r_reply = 1'b1;
					r_rtype = stt_pkg::TYPE_ACK;
					r_rseq = seq_q;
					r_found = 1'b1;
					wr_exp_val = seq_q + 32'd1;
					if (seq_q < exp_q) begin
						r_status = stt_pkg::ST_DUP;
					end else begin
						r_status = (seq_q > exp_q) ? stt_pkg::ST_AHEAD : stt_pkg::ST_IN_ORDER;
						wr_exp = 1'b1;
					end
				end else begin
					r_status = stt_pkg::ST_DATA_UNKNOWN;
				end
			end
			stt_pkg::TYPE_ACK: begin
				r_status = match_q ? stt_pkg::ST_ACK_SEEN : stt_pkg::ST_ACK_UNKNOWN;
				r_found = match_q;
			end
			stt_pkg::TYPE_CLOSE: begin
				if (match_q) begin
					r_status = stt_pkg::ST_CLOSED;
					r_found = 1'b1;
					clr_act = 1'b1;
				end else begin
					r_status = stt_pkg::ST_CLOSE_UNKNOWN;
				end
			end
			default: begin
				r_status = stt_pkg::ST_BAD_TYPE;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status <= r_status;
			send_reply <= r_reply;
			reply_type <= r_rtype;
			reply_seq <= r_rseq;
			slot_found <= r_found;
			slot_index <= r_found ? SlotW'(r_idx) : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/session_table_sequence_tracker_unit.sv @@
// Session table sequence tracker.
// Input channel (in_valid/in_ready) takes one parsed header per transfer:
// packet_type, conn_id and seq_number. Output channel (out_valid/out_ready)
// gives one result per header: status, reply fields and the slot used.
// Each header scans the whole slot table through one read port of the id and
// expected-sequence memories, one slot per cycle, keeping the lowest matching
// active slot and the lowest free slot. Once the last slot read has been
// compared, the result register loads as soon as it is free, and in_ready
// returns only after that load, so headers are processed one at a time.
// Reset clears all active marks at once; id and sequence memories are not
// cleared, and their contents are used only for active slots. No clearing pass is needed.
// A stalled receiver holds the result in the output register; the block
// takes the next header meanwhile and waits to load its result until the
// pending one is transferred. slot_index carries the low 5 bits of the slot.
`default_nettype none
`include "assert_macros.svh"

module session_table_sequence_tracker_unit #(
	parameter int SESSION_SLOTS = stt_pkg::SESSION_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  packet_type,
	input  logic [63:0] conn_id,
	input  logic [31:0] seq_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic        send_reply,
	output logic [7:0]  reply_type,
	output logic [31:0] reply_seq,
	output logic        slot_found,
	output logic [4:0]  slot_index
);

	stt_pkg::cmd_t  cmd;
	stt_pkg::stat_t stat;

	stt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	stt_datapath #(
		.SLOTS (SESSION_SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.packet_type (packet_type),
		.conn_id     (conn_id),
		.seq_number  (seq_number),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.send_reply  (send_reply),
		.reply_type  (reply_type),
		.reply_seq   (reply_seq),
		.slot_found  (slot_found),
		.slot_index  (slot_index)
	);

	`ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)
	`ASSERT_ALWAYS(a_no_reply_zero, !(out_valid && !send_reply) || (reply_type == 8'd0 && reply_seq == 32'd0))
	`ASSERT_ALWAYS(a_no_slot_zero, !(out_valid && !slot_found) || slot_index == 5'd0)
	`ASSERT_ALWAYS(a_reply_kind, !(out_valid && send_reply) || (reply_type == stt_pkg::TYPE_HS_ACK || reply_type == stt_pkg::TYPE_ACK))

endmodule

`default_nettype wire
